// File: src/tod_pkg.sv
// Shared types and constants for the time-of-day counter.
// Holds the op codes, the compare codes, the beat struct and the calendar constants.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package tod_pkg;

    // Calendar constants.
    localparam int unsigned SEC_PER_MIN  = 60;
    localparam int unsigned MIN_PER_HOUR = 60;
    localparam int unsigned HOUR_PER_DAY = 24;
    localparam int unsigned MAX_SECOND   = 59;
    localparam int unsigned MAX_MINUTE   = 59;
    localparam int unsigned MAX_HOUR     = 23;
    localparam int unsigned SEC_PER_HOUR = SEC_PER_MIN * MIN_PER_HOUR;
    localparam int unsigned SEC_PER_DAY  = SEC_PER_HOUR * HOUR_PER_DAY;

    // Reciprocals for the split of seconds of the day. Both round down, so
    // the quotient estimate is exact or one low and one correction fixes it.
    localparam int unsigned HOUR_RECIP_SHIFT = 24;
    localparam int unsigned HOUR_RECIP       = (1 << HOUR_RECIP_SHIFT) / SEC_PER_HOUR;
    localparam int unsigned MIN_RECIP_SHIFT  = 16;
    localparam int unsigned MIN_RECIP        = (1 << MIN_RECIP_SHIFT) / SEC_PER_MIN;

    // Operation codes.
    typedef enum logic [2:0] {
        OP_TICK_FWD = 3'd0,
        OP_TICK_BACK = 3'd1,
        OP_ADD_OFFSET = 3'd2,
        OP_SET_TIME = 3'd3,
        OP_COMPARE = 3'd4
    } t_op;

    // Compare result codes.
    typedef enum logic [1:0] {
        ORD_EARLIER = 2'd0,
        ORD_EQUAL = 2'd1,
        ORD_LATER = 2'd2
    } t_order;

    // Fields of an input beat that travel down the pipeline unchanged.
    typedef struct packed {
        t_op        op;
        logic [4:0] arg_hour;
        logic [5:0] arg_minute;
        logic [5:0] arg_second;
    } t_item;

endpackage

`default_nettype wire

// File: src/time_of_day_counter.sv
// Time-of-day counter: hour, minute and second register with tick, offset,
// set and compare operations, in a seven-stage pipeline.
// Depends on tod_pkg.
//
// Channel  Direction  Handshake                    Payload
// in       input      i_in_valid / o_in_ready      i_op, i_offset_seconds, i_arg_hour,
//                                                  i_arg_minute, i_arg_second
// out      output     o_out_valid / i_out_ready    o_cur_hour, o_cur_minute, o_cur_second,
//                                                  o_order, o_invalid
//
// One beat is accepted per cycle while o_in_ready is high; a result is offered
// once its beat has passed through seven registers (input register, modulo
// stage, two split stages per unit, state update into the output register).
// The offset is reduced modulo one day and split into hour, minute and second
// ahead of the state, so the state update is a short mixed-radix add.
// Each stage holds while the stage below it is full and stalled; empty stages
// keep accepting, so input stays ready while a result waits if any stage is empty.
// Synchronous active-low reset clears the time to midnight and empties all stages.
`timescale 1ns / 1ps
`default_nettype none

module time_of_day_counter (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [2:0]         i_op,
    input  wire logic signed [17:0] i_offset_seconds,
    input  wire logic [4:0]         i_arg_hour,
    input  wire logic [5:0]         i_arg_minute,
    input  wire logic [5:0]         i_arg_second,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [4:0]              o_cur_hour,
    output logic [5:0]              o_cur_minute,
    output logic [5:0]              o_cur_second,
    output logic [1:0]              o_order,
    output logic                    o_invalid
);

    localparam int unsigned NUM_STG = 7;

    // Stage valid bits and per-stage readiness.
    logic [NUM_STG-1:0] r_vld;
    logic [NUM_STG-1:0] n_vld;
    logic [NUM_STG-1:0] stg_rdy;

    // Stage payload registers.
    tod_pkg::t_item     r_s0_item, r_s1_item, r_s2_item, r_s3_item, r_s4_item, r_s5_item;
    logic signed [17:0] r_s0_off;
    logic [16:0]        r_s1_x, r_s2_x, n_s1_x;
    logic [4:0]         r_s2_qh, n_s2_qh;
    logic [4:0]         r_s3_dh, r_s4_dh, r_s5_dh, n_s3_dh;
    logic [11:0]        r_s3_rh, r_s4_rh, n_s3_rh;
    logic [5:0]         r_s4_qm, n_s4_qm;
    logic [5:0]         r_s5_dm, r_s5_ds, n_s5_dm, n_s5_ds;

    // Time state and output register.
    logic [4:0]         r_hours, n_hours;
    logic [5:0]         r_minutes, n_minutes;
    logic [5:0]         r_seconds, n_seconds;
    tod_pkg::t_order    r_out_order, n_out_order;
    logic               r_out_invalid, n_out_invalid;

    // Ready ripples up from the output: a stage takes a beat when it is empty
    // or its own beat moves on.
    always_comb begin
        stg_rdy[NUM_STG-1] = !r_vld[NUM_STG-1] || i_out_ready;
        for (int k = NUM_STG - 2; k >= 0; k--) begin
            stg_rdy[k] = !r_vld[k] || stg_rdy[k+1];
        end
        n_vld[0] = stg_rdy[0] ? i_in_valid : r_vld[0];
        for (int k = 1; k < NUM_STG; k++) begin
            n_vld[k] = stg_rdy[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    assign o_in_ready = stg_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // Stage 1: reduce the signed offset into 0 .. one day minus one second.
    logic signed [18:0] off_w, off_p1, off_p2, off_m1, day_s;
    always_comb begin
        day_s  = $signed({2'b00, 17'(tod_pkg::SEC_PER_DAY)});
        off_w  = {r_s0_off[17], r_s0_off};
        off_p1 = off_w + day_s;
        off_p2 = off_p1 + day_s;
        off_m1 = off_w - day_s;
        if (off_w < 0) begin
            n_s1_x = (off_p1 < 0) ? off_p2[16:0] : off_p1[16:0];
        end else if (off_w >= day_s) begin
            n_s1_x = off_m1[16:0];
        end else begin
            n_s1_x = off_w[16:0];
        end
    end

    // Stage 2: hour estimate by reciprocal multiplication.
    logic [29:0] prod_h;
    always_comb begin
        prod_h  = 30'(r_s1_x) * 30'(tod_pkg::HOUR_RECIP);
        n_s2_qh = prod_h[tod_pkg::HOUR_RECIP_SHIFT +: 5];
    end

    // Stage 3: hour remainder and correction of the estimate.
    logic [16:0] rh_w;
    always_comb begin
        rh_w = r_s2_x - 17'(r_s2_qh) * 17'(tod_pkg::SEC_PER_HOUR);
        if (rh_w >= 17'(tod_pkg::SEC_PER_HOUR)) begin
            n_s3_dh = r_s2_qh + 5'd1;
            n_s3_rh = 12'(rh_w - 17'(tod_pkg::SEC_PER_HOUR));
        end else begin
            n_s3_dh = r_s2_qh;
            n_s3_rh = rh_w[11:0];
        end
    end

    // Stage 4: minute estimate by reciprocal multiplication.
    logic [22:0] prod_m;
    always_comb begin
        prod_m  = 23'(r_s3_rh) * 23'(tod_pkg::MIN_RECIP);
        n_s4_qm = prod_m[tod_pkg::MIN_RECIP_SHIFT +: 6];
    end

    // Stage 5: minute remainder and correction of the estimate.
    logic [11:0] rm_w;
    always_comb begin
        rm_w = r_s4_rh - 12'(r_s4_qm) * 12'(tod_pkg::SEC_PER_MIN);
        if (rm_w >= 12'(tod_pkg::SEC_PER_MIN)) begin
            n_s5_dm = r_s4_qm + 6'd1;
            n_s5_ds = 6'(rm_w - 12'(tod_pkg::SEC_PER_MIN));
        end else begin
            n_s5_dm = r_s4_qm;
            n_s5_ds = rm_w[5:0];
        end
    end

    // Stage 6: apply the operation to the time and compare with the arguments.
    // A tick back is an add of one day minus one second.
    logic       upd;
    logic       set_ok;
    logic [4:0] d_h;
    logic [5:0] d_m, d_s;
    logic [6:0] s_sum, m_sum;
    logic [5:0] h_sum;
    logic       c_s, c_m;
    logic [5:0] add_s, add_m;
    logic [4:0] add_h;
    always_comb begin
        upd    = stg_rdy[6] && r_vld[5];
        set_ok = (r_s5_item.arg_hour <= 5'(tod_pkg::MAX_HOUR))
              && (r_s5_item.arg_minute <= 6'(tod_pkg::MAX_MINUTE))
              && (r_s5_item.arg_second <= 6'(tod_pkg::MAX_SECOND));
        case (r_s5_item.op)
            tod_pkg::OP_TICK_FWD: begin
                d_h = '0;
                d_m = '0;
                d_s = 6'd1;
            end
            tod_pkg::OP_TICK_BACK: begin
                d_h = 5'(tod_pkg::MAX_HOUR);
                d_m = 6'(tod_pkg::MAX_MINUTE);
                d_s = 6'(tod_pkg::MAX_SECOND);
            end
            tod_pkg::OP_ADD_OFFSET: begin
                d_h = r_s5_dh;
                d_m = r_s5_dm;
                d_s = r_s5_ds;
            end
            default: begin
                d_h = '0;
                d_m = '0;
                d_s = '0;
            end
        endcase

        s_sum = {1'b0, r_seconds} + {1'b0, d_s};
        c_s   = s_sum >= 7'(tod_pkg::SEC_PER_MIN);
        add_s = c_s ? 6'(s_sum - 7'(tod_pkg::SEC_PER_MIN)) : s_sum[5:0];
        m_sum = {1'b0, r_minutes} + {1'b0, d_m} + {6'd0, c_s};
        c_m   = m_sum >= 7'(tod_pkg::MIN_PER_HOUR);
        add_m = c_m ? 6'(m_sum - 7'(tod_pkg::MIN_PER_HOUR)) : m_sum[5:0];
        h_sum = {1'b0, r_hours} + {1'b0, d_h} + {5'd0, c_m};
        add_h = (h_sum >= 6'(tod_pkg::HOUR_PER_DAY))
              ? 5'(h_sum - 6'(tod_pkg::HOUR_PER_DAY)) : h_sum[4:0];

        n_out_invalid = 1'b0;
        if (r_s5_item.op == tod_pkg::OP_SET_TIME) begin
            if (set_ok) begin
                n_hours   = r_s5_item.arg_hour;
                n_minutes = r_s5_item.arg_minute;
                n_seconds = r_s5_item.arg_second;
            end else begin
                n_hours       = r_hours;
                n_minutes     = r_minutes;
                n_seconds     = r_seconds;
                n_out_invalid = 1'b1;
            end
        end else begin
            n_hours   = add_h;
            n_minutes = add_m;
            n_seconds = add_s;
        end

        // Hour, minute and second concatenate into one lexicographic key.
        if ({n_hours, n_minutes, n_seconds}
                > {r_s5_item.arg_hour, r_s5_item.arg_minute, r_s5_item.arg_second}) begin
            n_out_order = tod_pkg::ORD_LATER;
        end else if ({n_hours, n_minutes, n_seconds}
                == {r_s5_item.arg_hour, r_s5_item.arg_minute, r_s5_item.arg_second}) begin
            n_out_order = tod_pkg::ORD_EQUAL;
        end else begin
            n_out_order = tod_pkg::ORD_EARLIER;
        end
    end

    // Time state, cleared by reset and updated once per beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hours   <= '0;
            r_minutes <= '0;
            r_seconds <= '0;
        end else if (upd) begin
            r_hours   <= n_hours;
            r_minutes <= n_minutes;
            r_seconds <= n_seconds;
        end
    end

    // Payload registers, each loaded when its stage takes a beat.
    always_ff @(posedge i_clk) begin
        if (stg_rdy[0]) begin
            r_s0_item <= '{op: tod_pkg::t_op'(i_op), arg_hour: i_arg_hour,
                           arg_minute: i_arg_minute, arg_second: i_arg_second};
            r_s0_off  <= i_offset_seconds;
        end
        if (stg_rdy[1]) begin
            r_s1_item <= r_s0_item;
            r_s1_x    <= n_s1_x;
        end
        if (stg_rdy[2]) begin
            r_s2_item <= r_s1_item;
            r_s2_x    <= r_s1_x;
            r_s2_qh   <= n_s2_qh;
        end
        if (stg_rdy[3]) begin
            r_s3_item <= r_s2_item;
            r_s3_dh   <= n_s3_dh;
            r_s3_rh   <= n_s3_rh;
        end
        if (stg_rdy[4]) begin
            r_s4_item <= r_s3_item;
            r_s4_dh   <= r_s3_dh;
            r_s4_rh   <= r_s3_rh;
            r_s4_qm   <= n_s4_qm;
        end
        if (stg_rdy[5]) begin
            r_s5_item <= r_s4_item;
            r_s5_dh   <= r_s4_dh;
            r_s5_dm   <= n_s5_dm;
            r_s5_ds   <= n_s5_ds;
        end
        if (upd) begin
            r_out_order   <= n_out_order;
            r_out_invalid <= n_out_invalid;
        end
    end

    // The output register shows the time held after the last beat.
    assign o_out_valid  = r_vld[NUM_STG-1];
    assign o_cur_hour   = r_hours;
    assign o_cur_minute = r_minutes;
    assign o_cur_second = r_seconds;
    assign o_order      = r_out_order;
    assign o_invalid    = r_out_invalid;

    // The time never leaves the legal range of a day.
    a_time_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hours <= 5'(tod_pkg::MAX_HOUR)) && (r_minutes <= 6'(tod_pkg::MAX_MINUTE))
        && (r_seconds <= 6'(tod_pkg::MAX_SECOND)))
        else $error("time state out of range");

    // Only a set raises the invalid flag.
    a_invalid_only_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        upd && (r_s5_item.op != tod_pkg::OP_SET_TIME) |=> !o_invalid)
        else $error("invalid raised by an operation other than set");

    // A legal set lands in the time and compares equal.
    a_set_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        upd && (r_s5_item.op == tod_pkg::OP_SET_TIME) && set_ok
        |=> (o_cur_hour == $past(r_s5_item.arg_hour))
            && (o_cur_minute == $past(r_s5_item.arg_minute))
            && (o_cur_second == $past(r_s5_item.arg_second))
            && (o_order == tod_pkg::ORD_EQUAL))
        else $error("legal set did not load the time");

    // With every stage full, input readiness follows the output side.
    a_full_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_vld) |-> (o_in_ready == i_out_ready))
        else $error("input ready inconsistent with a full pipeline");

endmodule

`default_nettype wire
